>>> rtl/rgba_box_downscale_2x2_assert.svh
// assertion macros used by rgba_box_downscale_2x2.sv
`ifndef RGBA_BOX_DOWNSCALE_2X2_ASSERT_SVH
`define RGBA_BOX_DOWNSCALE_2X2_ASSERT_SVH

// same-cycle implication
`define RBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbd assertion failed");

// next-cycle implication
`define RBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbd assertion failed");

`endif

>>> rtl/rbd_pkg.sv
`default_nettype none

package rbd_pkg;

   // pixel channel and pair-sum lane widths
   localparam int unsigned CHANNELS  = 4;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned LANE_W    = 9;
   localparam int unsigned CFG_W     = 13;
   localparam int unsigned ROW_W     = 12;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [CFG_W-1:0] DIM_MIN      = 13'd2;
   localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 13'd4096;

   // register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef logic [LANE_W-1:0] lane_type;
   typedef lane_type [CHANNELS-1:0] pair_type;

   // line store port controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

endpackage

`default_nettype wire

>>> rtl/rbd_line_store.sv
`default_nettype none

module rbd_line_store #(
   parameter int unsigned DEPTH = 2048,
   parameter int unsigned IDX_W = 11
) (
   input  wire logic                  clock,
   input  wire rbd_pkg::ram_ctl_type  ctl,
   input  wire logic [IDX_W-1:0]      addr,
   input  wire rbd_pkg::pair_type     wr_data,
   output rbd_pkg::pair_type          rd_data
);

   rbd_pkg::pair_type mem [DEPTH];
   rbd_pkg::pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // registered read, holds until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/rgba_box_downscale_2x2.sv
`default_nettype none
// 2x2 box downscaler for an rgba pixel stream.
// req_ channel: one input pixel per transfer, raster order, frame of
//   frame_width by frame_height pixels (csr index 0 and 1, clamped to
//   2..MAX_WIDTH and 2..4096). a trailing odd column or row is consumed
//   without output.
// rsp_ channel: one averaged pixel per 2x2 block, emitted on the second
//   pixel of each pair in odd rows; rsp_frame_end marks the last one.
// throughput: one pixel per clock while req_ready is high; the line
//   store takes one access per pixel pair (a write on even rows, a read
//   on odd rows) on its single port; a result reaches rsp_ through the
//   line store read, then the output register.
// stall: the output register and the read stage together keep taking
//   pixels while a result waits; req_ready falls only when both hold a
//   result.
// reset: counters return to frame start, sizes to 640 x 480. the line
//   store needs no clearing pass; every read entry is written in the
//   even row before it.
// csr writes are taken at any edge with csr_wr_en and apply to the next
//   pixel; write them between frames.

`include "rgba_box_downscale_2x2_assert.svh"

module rgba_box_downscale_2x2 #(
   parameter int unsigned MAX_WIDTH = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // input pixels
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [rbd_pkg::CHAN_W-1:0]  req_in_red,
   input  wire logic [rbd_pkg::CHAN_W-1:0]  req_in_green,
   input  wire logic [rbd_pkg::CHAN_W-1:0]  req_in_blue,
   input  wire logic [rbd_pkg::CHAN_W-1:0]  req_in_alpha,
   // output pixels
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [rbd_pkg::CHAN_W-1:0]       rsp_out_red,
   output logic [rbd_pkg::CHAN_W-1:0]       rsp_out_green,
   output logic [rbd_pkg::CHAN_W-1:0]       rsp_out_blue,
   output logic [rbd_pkg::CHAN_W-1:0]       rsp_out_alpha,
   output logic                             rsp_frame_end,
   // configuration writes
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_index,
   input  wire logic [rbd_pkg::CFG_W-1:0]   csr_wdata
);

   localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
   localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
   localparam int unsigned IDX_W      = $clog2(LINE_DEPTH);
   localparam int unsigned W_W        = $clog2(MAX_WIDTH + 1);
   localparam int unsigned CMP_W      = (W_W > rbd_pkg::CFG_W) ? W_W : rbd_pkg::CFG_W;
   localparam int unsigned ROW_W      = rbd_pkg::ROW_W;
   localparam int unsigned CFG_W      = rbd_pkg::CFG_W;
   localparam int unsigned CHANNELS   = rbd_pkg::CHANNELS;
   localparam int unsigned CHAN_W     = rbd_pkg::CHAN_W;
   localparam int unsigned LANE_W     = rbd_pkg::LANE_W;
   localparam logic [CMP_W-1:0] WIDTH_MAX = CMP_W'(MAX_WIDTH);

   // configuration registers
   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;

   // frame position and first pixel of the current pair
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   rbd_pkg::pair_type hold_ff, hold_in;

   // read stage: pair sum of the odd row waiting for the line store data
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_end_ff, s1_end_in;
   rbd_pkg::pair_type s1_sum_ff, s1_sum_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_end_ff, rsp_end_in;
   logic [CHANNELS-1:0][CHAN_W-1:0] rsp_pix_ff, rsp_pix_in;

   // datapath signals
   logic [CMP_W-1:0]   width_lim, width_even, col_ext, col_next;
   logic [CFG_W-1:0]   height_lim, height_even, row_ext, row_next;
   logic [COL_W-1:0]   col_eff;
   logic [ROW_W-1:0]   row_eff;
   logic               in_frame, out_free, req_fire, produce, last_pix;
   rbd_pkg::pair_type  pix, pair_sum, above;
   rbd_pkg::ram_ctl_type ram_ctl;
   logic [IDX_W-1:0]   ram_addr;
   logic [LANE_W:0]    quad_sum [CHANNELS];

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   // clamp frame size, even limits
   always_comb begin
      width_lim = CMP_W'(frame_width_ff);
      if (width_lim < CMP_W'(rbd_pkg::DIM_MIN)) begin
         width_lim = CMP_W'(rbd_pkg::DIM_MIN);
      end else if (width_lim > WIDTH_MAX) begin
         width_lim = WIDTH_MAX;
      end
      height_lim = frame_height_ff;
      if (height_lim < rbd_pkg::DIM_MIN) begin
         height_lim = rbd_pkg::DIM_MIN;
      end else if (height_lim > rbd_pkg::HEIGHT_LIMIT) begin
         height_lim = rbd_pkg::HEIGHT_LIMIT;
      end
      width_even  = {width_lim[CMP_W-1:1], 1'b0};
      height_even = {height_lim[CFG_W-1:1], 1'b0};
   end

   // position of this pixel, counters beyond the frame read as zero
   always_comb begin
      col_eff  = (CMP_W'(col_ff) >= width_lim) ? '0 : col_ff;
      row_eff  = (CFG_W'(row_ff) >= height_lim) ? '0 : row_ff;
      col_ext  = CMP_W'(col_eff);
      row_ext  = CFG_W'(row_eff);
      col_next = col_ext + CMP_W'(1);
      row_next = row_ext + CFG_W'(1);
      in_frame = (col_ext < width_even) && (row_ext < height_even);
      last_pix = (row_ext == height_even - CFG_W'(1)) &&
                 (col_ext == width_even - CMP_W'(1));
   end

   // pixel lanes and horizontal pair sum
   always_comb begin
      pix[0] = LANE_W'(req_in_red);
      pix[1] = LANE_W'(req_in_green);
      pix[2] = LANE_W'(req_in_blue);
      pix[3] = LANE_W'(req_in_alpha);
      for (int c = 0; c < CHANNELS; c++) begin
         pair_sum[c] = hold_ff[c] + pix[c];
      end
   end

   // line store access: even rows write, odd rows read
   always_comb begin
      ram_addr      = col_eff[IDX_W:1];
      ram_ctl.wr_en = req_fire && in_frame && col_eff[0] && !row_eff[0];
      ram_ctl.rd_en = req_fire && in_frame && col_eff[0] && row_eff[0];
      produce       = ram_ctl.rd_en;
   end

   rbd_line_store #(
      .DEPTH (LINE_DEPTH),
      .IDX_W (IDX_W)
   ) u_line_store (
      .clock   (clock),
      .ctl     (ram_ctl),
      .addr    (ram_addr),
      .wr_data (pair_sum),
      .rd_data (above)
   );

   // next state of counters, hold and config
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rbd_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            rbd_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end

      col_in  = col_ff;
      row_in  = row_ff;
      hold_in = hold_ff;
      if (req_fire) begin
         if (in_frame && !col_eff[0]) begin
            hold_in = pix;
         end
         if (col_next >= width_lim) begin
            col_in = '0;
            row_in = (row_next >= height_lim) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
            row_in = row_eff;
         end
      end
   end

   // vertical add and divide by four
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         quad_sum[c] = (LANE_W+1)'(above[c]) + (LANE_W+1)'(s1_sum_ff[c]);
         rsp_pix_in[c] = quad_sum[c][LANE_W:2];
      end
   end

   // read stage and output register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_sum_in    = s1_sum_ff;
      s1_end_in    = s1_end_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_end_in   = rsp_end_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         rsp_end_in   = s1_end_ff;
         s1_valid_in  = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = produce;
         s1_sum_in   = pair_sum;
         s1_end_in   = last_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rbd_pkg::WIDTH_RESET;
         frame_height_ff <= rbd_pkg::HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         hold_ff         <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         hold_ff         <= hold_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_sum_ff  <= s1_sum_in;
      s1_end_ff  <= s1_end_in;
      rsp_end_ff <= rsp_end_in;
      if (out_free && s1_valid_ff) begin
         rsp_pix_ff <= rsp_pix_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pix_ff[0];
   assign rsp_out_green = rsp_pix_ff[1];
   assign rsp_out_blue  = rsp_pix_ff[2];
   assign rsp_out_alpha = rsp_pix_ff[3];
   assign rsp_frame_end = rsp_end_ff;

   // single-port line store: never written and read at once
   `RBD_ASSERT_NOW(a_ram_one_access, clock, reset, ram_ctl.wr_en, !ram_ctl.rd_en)
   // every line store read feeds a result in the read stage
   `RBD_ASSERT_NEXT(a_read_fills_s1, clock, reset, ram_ctl.rd_en, s1_valid_ff)
   // a blocked read stage keeps its pair sum
   `RBD_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !out_free,
                    s1_valid_ff && $stable(s1_sum_ff))
   // input stalls only when both result slots are full
   `RBD_ASSERT_NOW(a_ready_low_full, clock, reset, !req_ready,
                   s1_valid_ff && rsp_valid_ff)

endmodule

`default_nettype wire
